[design/ir_pulse_distance_frame_decoder_assert.svh]
// Assertion macros used by the decoder RTL.
// Each check is clocked on clock and masked while reset is high.
`ifndef IR_PULSE_DISTANCE_FRAME_DECODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication.
`define IPD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IPD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/ipd_pkg.sv]
package ipd_pkg;

   // Field widths
   localparam int DUR_W  = 16;
   localparam int BITS_W = 35;
   localparam int POS_W  = 8;
   localparam int IDX_W  = 3;

   // Frame layout
   localparam int FIRST_PART_BITS  = 35;
   localparam int SECOND_PART_BITS = 32;
   localparam int SEP_POS_I        = 2 + 2 * FIRST_PART_BITS;
   localparam int SECOND_POS_I     = SEP_POS_I + 2;
   localparam int END_POS_I        = SECOND_POS_I + 2 * SECOND_PART_BITS;

   localparam logic [POS_W-1:0] SEP_POS      = POS_W'(SEP_POS_I);
   localparam logic [POS_W-1:0] GAP_POS      = POS_W'(SEP_POS_I + 1);
   localparam logic [POS_W-1:0] FIRST_LAST   = POS_W'(SEP_POS_I - 1);
   localparam logic [POS_W-1:0] SECOND_LAST  = POS_W'(END_POS_I - 1);
   localparam logic [POS_W-1:0] DATA_START   = POS_W'(2);

   // Register reset values
   localparam logic [DUR_W-1:0] MARK_NOM_RST  = DUR_W'(600);
   localparam logic [DUR_W-1:0] MARK_TOL_RST  = DUR_W'(100);
   localparam logic [DUR_W-1:0] ONE_NOM_RST   = DUR_W'(1600);
   localparam logic [DUR_W-1:0] ONE_TOL_RST   = DUR_W'(200);
   localparam logic [DUR_W-1:0] ZERO_NOM_RST  = DUR_W'(600);
   localparam logic [DUR_W-1:0] ZERO_TOL_RST  = DUR_W'(200);

   typedef enum logic [IDX_W-1:0] {
      CSR_MARK_NOM  = 3'd0,
      CSR_MARK_TOL  = 3'd1,
      CSR_ONE_NOM   = 3'd2,
      CSR_ONE_TOL   = 3'd3,
      CSR_ZERO_NOM  = 3'd4,
      CSR_ZERO_TOL  = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MARK  = 2'd1,
      ST_SPACE = 2'd2
   } status_type;

   typedef struct packed {
      logic [DUR_W-1:0] mark_nominal;
      logic [DUR_W-1:0] mark_tolerance;
      logic [DUR_W-1:0] one_nominal;
      logic [DUR_W-1:0] one_tolerance;
      logic [DUR_W-1:0] zero_nominal;
      logic [DUR_W-1:0] zero_tolerance;
   } cfg_type;

   typedef struct packed {
      logic [BITS_W-1:0] part_bits;
      logic              part_index;
      status_type        status;
   } result_type;

   // True when |d - nom| is strictly below tol
   function automatic logic near_value(input logic [DUR_W-1:0] d,
                                       input logic [DUR_W-1:0] nom,
                                       input logic [DUR_W-1:0] tol);
      logic [DUR_W-1:0] dev;
      dev = (d > nom) ? (d - nom) : (nom - d);
      return dev < tol;
   endfunction

endpackage

[design/ir_pulse_distance_frame_decoder.sv]
// Channel  Ports                                        Role
// -------  -------------------------------------------  -----------------------------
// req      req_valid/req_ready, duration, frame_start   one mark or space per beat
// rsp      rsp_valid/rsp_ready, part_bits/index/status  one beat per part or error
// csr      csr_wr_en, csr_index, csr_wdata              timing register writes
//
// One beat is taken per cycle while no result waits untaken. A beat is held in the input
// register, is decoded against the frame state and, if it ends a part or fails, is
// loaded into the result register, which drives the rsp beat.
// Reset is synchronous: control and timing registers return to defaults and the decoder idles.
// A result held in the result register stalls the input register until taken.
module ir_pulse_distance_frame_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ipd_pkg::DUR_W-1:0]     req_duration,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ipd_pkg::BITS_W-1:0]    rsp_part_bits,
   output logic                          rsp_part_index,
   output ipd_pkg::status_type           rsp_status,
   input  logic                          csr_wr_en,
   input  logic [ipd_pkg::IDX_W-1:0]     csr_index,
   input  logic [ipd_pkg::DUR_W-1:0]     csr_wdata
);
   import ipd_pkg::*;

   `include "ir_pulse_distance_frame_decoder_assert.svh"

   cfg_type          cfg;
   logic             in_valid_ff;
   logic [DUR_W-1:0] dur_ff;
   logic             start_ff;
   logic             advance;
   logic             emit;
   result_type       result;
   logic             rsp_valid_ff;
   result_type       rsp_ff;

   ipd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Move the held beat on unless a result is waiting and not taken
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         dur_ff   <= req_duration;
         start_ff <= req_frame_start;
      end
   end

   ipd_step u_step (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .duration    (dur_ff),
      .frame_start (start_ff),
      .cfg         (cfg),
      .emit        (emit),
      .result      (result)
   );

   // Result register: load on emit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_part_bits  = rsp_ff.part_bits;
   assign rsp_part_index = rsp_ff.part_index;
   assign rsp_status     = rsp_ff.status;

   `IPD_ASSERT_IMP(a_err_zero_bits, rsp_valid_ff && rsp_ff.status != ST_OK,
      rsp_ff.part_bits == '0, "error result carries nonzero bits")
   `IPD_ASSERT_IMP(a_second_width,
      rsp_valid_ff && rsp_ff.status == ST_OK && rsp_ff.part_index,
      rsp_ff.part_bits[BITS_W-1:SECOND_PART_BITS] == '0,
      "second part wider than its bit count")
   `IPD_ASSERT_NXT(a_emit_loads, advance && emit, rsp_valid_ff,
      "emitted result not held in result register")
   `IPD_ASSERT_NXT(a_stall_holds, in_valid_ff && !advance,
      in_valid_ff && $stable(dur_ff) && $stable(start_ff),
      "stalled input beat lost")

endmodule

[design/ipd_csr.sv]
module ipd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [ipd_pkg::IDX_W-1:0]   csr_index,
   input  logic [ipd_pkg::DUR_W-1:0]   csr_wdata,
   output ipd_pkg::cfg_type            cfg
);
   import ipd_pkg::*;

   cfg_type cfg_ff;

   // Load reset values, then take writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mark_nominal   <= MARK_NOM_RST;
         cfg_ff.mark_tolerance <= MARK_TOL_RST;
         cfg_ff.one_nominal    <= ONE_NOM_RST;
         cfg_ff.one_tolerance  <= ONE_TOL_RST;
         cfg_ff.zero_nominal   <= ZERO_NOM_RST;
         cfg_ff.zero_tolerance <= ZERO_TOL_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MARK_NOM: begin
               cfg_ff.mark_nominal <= csr_wdata;
            end
            CSR_MARK_TOL: begin
               cfg_ff.mark_tolerance <= csr_wdata;
            end
            CSR_ONE_NOM: begin
               cfg_ff.one_nominal <= csr_wdata;
            end
            CSR_ONE_TOL: begin
               cfg_ff.one_tolerance <= csr_wdata;
            end
            CSR_ZERO_NOM: begin
               cfg_ff.zero_nominal <= csr_wdata;
            end
            CSR_ZERO_TOL: begin
               cfg_ff.zero_tolerance <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/ipd_step.sv]
module ipd_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [ipd_pkg::DUR_W-1:0]   duration,
   input  logic                        frame_start,
   input  ipd_pkg::cfg_type            cfg,
   output logic                        emit,
   output ipd_pkg::result_type         result
);
   import ipd_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              active_ff, active_in;
   logic [BITS_W-1:0] shift_ff, shift_in;

   logic              act;
   logic [POS_W-1:0]  pos;
   logic [BITS_W-1:0] shf;
   logic              mark_ok, one_ok, zero_ok;
   logic              part;

   // A start beat restarts the frame from position zero
   assign act = frame_start | active_ff;
   assign pos = frame_start ? '0 : pos_ff;
   assign shf = frame_start ? '0 : shift_ff;
   assign part = (pos >= SEP_POS);

   assign mark_ok = near_value(duration, cfg.mark_nominal, cfg.mark_tolerance);
   assign one_ok  = near_value(duration, cfg.one_nominal, cfg.one_tolerance);
   assign zero_ok = near_value(duration, cfg.zero_nominal, cfg.zero_tolerance);

   // Decode one beat: check marks, shift in space bits, emit on part end or error
   always_comb begin
      pos_in            = pos_ff;
      active_in         = active_ff;
      shift_in          = shift_ff;
      emit              = 1'b0;
      result.part_bits  = '0;
      result.part_index = part;
      result.status     = ST_OK;
      if (fire && act) begin
         pos_in    = pos + POS_W'(1);
         active_in = 1'b1;
         shift_in  = shf;
         if (pos < DATA_START || pos == SEP_POS || pos == GAP_POS) begin
            // header, separator and gap pass unchecked
         end else if (!pos[0]) begin
            if (!mark_ok) begin
               active_in     = 1'b0;
               emit          = 1'b1;
               result.status = ST_MARK;
            end
         end else if (!one_ok && !zero_ok) begin
            active_in     = 1'b0;
            emit          = 1'b1;
            result.status = ST_SPACE;
         end else begin
            shift_in = {shf[BITS_W-2:0], one_ok};
            if (pos == FIRST_LAST || pos == SECOND_LAST) begin
               emit             = 1'b1;
               result.part_bits = shift_in;
               shift_in         = '0;
               if (pos == SECOND_LAST) begin
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   // Hold frame state between beats
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         active_ff <= 1'b0;
         shift_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
         shift_ff  <= shift_in;
      end
   end

endmodule

[verif/ir_pulse_distance_frame_decoder_test.sv]
module ir_pulse_distance_frame_decoder_test;
   import ipd_pkg::*;

   localparam int DRAIN_SLACK = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 5000;

   // Spare register indexes beyond the six timing registers
   localparam logic [IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef enum int {
      FRAME_CLEAN,
      FRAME_MARK_FAULT,
      FRAME_SPACE_FAULT,
      FRAME_CUT
   } frame_kind_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [DUR_W-1:0]    req_duration = '0;
   logic                req_frame_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BITS_W-1:0]   rsp_part_bits;
   logic                rsp_part_index;
   status_type          rsp_status;
   logic                csr_wr_en = 1'b0;
   logic [IDX_W-1:0]    csr_index = '0;
   logic [DUR_W-1:0]    csr_wdata = '0;

   // Decoder mirror: timing registers and frame state
   cfg_type             timing = '{MARK_NOM_RST, MARK_TOL_RST, ONE_NOM_RST, ONE_TOL_RST,
                                   ZERO_NOM_RST, ZERO_TOL_RST};
   bit                  frame_open = 1'b0;
   logic [POS_W-1:0]    frame_pos = '0;
   logic [BITS_W-1:0]   shift_bits = '0;
   result_type          expected_parts[$];

   int                  mismatches = 0;
   int                  quiet_cycles = 0;
   int                  rsp_hold_request = 0;
   bit                  steady = 1'b0;
   bit                  req_armed = 1'b0;

   ir_pulse_distance_frame_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_duration    (req_duration),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_part_bits   (rsp_part_bits),
      .rsp_part_index  (rsp_part_index),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Strict band test: |d - nom| < tol
   function automatic bit in_band(input logic [DUR_W-1:0] d, input logic [DUR_W-1:0] nom,
                                  input logic [DUR_W-1:0] tol);
      int spread;
      spread = int'(d) - int'(nom);
      if (spread < 0) spread = -spread;
      return spread < int'(tol);
   endfunction

   function automatic void queue_part(input logic [BITS_W-1:0] bits, input logic idx,
                                      input status_type st);
      result_type r;
      r.part_bits  = bits;
      r.part_index = idx;
      r.status     = st;
      expected_parts = {expected_parts, r};
   endfunction

   // Advance the frame mirror by one beat; return 1 when the beat is part of a frame
   function automatic bit decode_beat(input logic [DUR_W-1:0] dur, input logic start);
      logic [POS_W-1:0] at;
      logic             part;
      if (start) begin
         frame_open = 1'b1;
         frame_pos  = '0;
         shift_bits = '0;
      end
      if (!frame_open) return 1'b0;
      at = frame_pos;
      frame_pos = at + 1'b1;
      part = (at >= SEP_POS);
      // header and separator are not checked
      if (at < DATA_START || at == SEP_POS || at == GAP_POS) return 1'b1;
      if (!at[0]) begin
         if (!in_band(dur, timing.mark_nominal, timing.mark_tolerance)) begin
            frame_open = 1'b0;
            queue_part('0, part, ST_MARK);
         end
         return 1'b1;
      end
      // one is tested before zero
      if (in_band(dur, timing.one_nominal, timing.one_tolerance)) begin
         shift_bits = {shift_bits[BITS_W-2:0], 1'b1};
      end else if (in_band(dur, timing.zero_nominal, timing.zero_tolerance)) begin
         shift_bits = {shift_bits[BITS_W-2:0], 1'b0};
      end else begin
         frame_open = 1'b0;
         queue_part('0, part, ST_SPACE);
         return 1'b1;
      end
      if (at == FIRST_LAST) begin
         queue_part(shift_bits, 1'b0, ST_OK);
         shift_bits = '0;
      end else if (at == SECOND_LAST) begin
         queue_part(shift_bits, 1'b1, ST_OK);
         shift_bits = '0;
         frame_open = 1'b0;
      end
      return 1'b1;
   endfunction

   // Mostly short gaps, a few long ones; none in steady stretches
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic logic [DUR_W-1:0] pick_near(input logic [DUR_W-1:0] nom,
                                                  input logic [DUR_W-1:0] tol);
      int off;
      int v;
      off = (tol == 0) ? 0 : $urandom_range(0, int'(tol) - 1);
      v = $urandom_range(0, 1) ? int'(nom) + off : int'(nom) - off;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return DUR_W'(v);
   endfunction

   function automatic logic [DUR_W-1:0] pick_far(input logic [DUR_W-1:0] nom,
                                                 input logic [DUR_W-1:0] tol);
      int off;
      int v;
      off = int'(tol) + $urandom_range(0, 3000);
      v = $urandom_range(0, 1) ? int'(nom) + off : int'(nom) - off;
      if (v < 0) v = int'(nom) + off;
      if (v > 65535) v = int'(nom) - off;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return DUR_W'(v);
   endfunction

   // Look for a space outside both bit bands; give up after a few tries
   function automatic logic [DUR_W-1:0] pick_bad_space();
      logic [DUR_W-1:0] d;
      int tries;
      tries = 0;
      d = pick_far(timing.one_nominal, timing.one_tolerance);
      while (tries < 8 && (in_band(d, timing.one_nominal, timing.one_tolerance) ||
                           in_band(d, timing.zero_nominal, timing.zero_tolerance))) begin
         case ($urandom_range(0, 2))
            0: d = pick_far(timing.one_nominal, timing.one_tolerance);
            1: d = pick_far(timing.zero_nominal, timing.zero_tolerance);
            default: d = DUR_W'($urandom_range(0, 65535));
         endcase
         tries++;
      end
      return d;
   endfunction

   // Offer one beat, hold it until taken, then mirror it
   task automatic send_beat(input logic [DUR_W-1:0] dur, input logic start, input int gap);
      req_valid       <= 1'b1;
      req_duration    <= dur;
      req_frame_start <= start;
      req_armed = 1'b1;
      do @(posedge clock); while (!req_ready);
      void'(decode_beat(dur, start));
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_armed = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected beat is out, plus slack
   task automatic wait_drained();
      if (req_armed) begin
         req_valid <= 1'b0;
         req_armed = 1'b0;
      end
      while (expected_parts.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MARK_NOM: timing.mark_nominal   = val;
         CSR_MARK_TOL: timing.mark_tolerance = val;
         CSR_ONE_NOM:  timing.one_nominal    = val;
         CSR_ONE_TOL:  timing.one_tolerance  = val;
         CSR_ZERO_NOM: timing.zero_nominal   = val;
         CSR_ZERO_TOL: timing.zero_tolerance = val;
         default: ;
      endcase
   endtask

   task automatic program_timing(input cfg_type c, input bit stray);
      write_reg(CSR_MARK_NOM, c.mark_nominal);
      write_reg(CSR_MARK_TOL, c.mark_tolerance);
      write_reg(CSR_ONE_NOM, c.one_nominal);
      write_reg(CSR_ONE_TOL, c.one_tolerance);
      write_reg(CSR_ZERO_NOM, c.zero_nominal);
      write_reg(CSR_ZERO_TOL, c.zero_tolerance);
      // unused indexes must leave the timing untouched
      if (stray) begin
         write_reg(CSR_SPARE_A, 16'hFFFF);
         write_reg(CSR_SPARE_B, 16'h0000);
      end
      csr_wr_en <= 1'b0;
   endtask

   // One frame with random bits, optionally broken or cut short
   task automatic run_frame(input frame_kind_type kind);
      int last;
      int fault_at;
      int p;
      logic [DUR_W-1:0] dur;
      last = END_POS_I - 1;
      fault_at = -1;
      steady = ($urandom_range(0, 4) == 0);
      case (kind)
         FRAME_MARK_FAULT, FRAME_SPACE_FAULT: begin
            fault_at = $urandom_range(0, 1) ? $urandom_range(2, 20) : $urandom_range(2, last);
            if (fault_at == SEP_POS_I || fault_at == SEP_POS_I + 1) fault_at += 2;
            fault_at = (kind == FRAME_MARK_FAULT) ? (fault_at & ~1) : (fault_at | 1);
            last = fault_at;
         end
         FRAME_CUT: last = $urandom_range(0, END_POS_I - 2);
         default: ;
      endcase
      for (p = 0; p <= last; p++) begin
         if (p < 2 || p == SEP_POS_I || p == SEP_POS_I + 1)
            dur = DUR_W'($urandom_range(0, 65535));
         else if (p[0] == 1'b0)
            dur = (p == fault_at) ? pick_far(timing.mark_nominal, timing.mark_tolerance)
                                  : pick_near(timing.mark_nominal, timing.mark_tolerance);
         else if (p == fault_at)
            dur = pick_bad_space();
         else
            dur = $urandom_range(0, 1) ? pick_near(timing.one_nominal, timing.one_tolerance)
                                       : pick_near(timing.zero_nominal, timing.zero_tolerance);
         send_beat(dur, p == 0, pick_gap());
      end
      // trailing beats while idle are dropped
      if (kind != FRAME_CUT)
         repeat ($urandom_range(0, 2))
            send_beat(DUR_W'($urandom_range(0, 65535)), 1'b0, pick_gap());
      steady = 1'b0;
   endtask

   // Band edges, clipped durations, both error kinds, restart mid-frame
   task automatic test_directed();
      send_beat(16'hFFFF, 1'b0, pick_gap());   // idle, no start: ignored
      send_beat(16'h0000, 1'b1, pick_gap());   // header mark
      send_beat(16'hFFFF, 1'b0, pick_gap());   // header space, unchecked
      send_beat(16'd699, 1'b0, pick_gap());    // mark just inside
      send_beat(16'd1799, 1'b0, pick_gap());   // one just inside
      send_beat(16'd501, 1'b0, pick_gap());
      send_beat(16'd401, 1'b0, pick_gap());    // zero just inside
      send_beat(16'd700, 1'b0, pick_gap());    // mark on the edge: fails
      send_beat(16'd600, 1'b0, pick_gap());    // idle after error: ignored
      send_beat(16'd9000, 1'b1, pick_gap());
      send_beat(16'd4500, 1'b0, pick_gap());
      send_beat(16'd600, 1'b0, pick_gap());
      send_beat(16'd1800, 1'b0, pick_gap());   // space in neither band
      send_beat(16'd9000, 1'b1, pick_gap());
      send_beat(16'd4500, 1'b0, pick_gap());
      send_beat(16'd600, 1'b0, pick_gap());
      send_beat(16'd9000, 1'b1, pick_gap());   // restart drops the running frame
      send_beat(16'd4500, 1'b0, pick_gap());
      send_beat(16'h0000, 1'b0, pick_gap());   // zero mark fails
      send_beat(16'd9000, 1'b1, pick_gap());
      send_beat(16'd4500, 1'b0, pick_gap());
      send_beat(16'd500, 1'b0, pick_gap());    // low mark edge fails
      wait_drained();
   endtask

   // Hold the receiver off while short failing frames pile up
   task automatic test_backpressure();
      rsp_hold_request = HOLD_CYCLES;
      repeat (16) begin
         send_beat(16'd9000, 1'b1, 0);
         send_beat(16'd4500, 1'b0, 0);
         send_beat(pick_far(timing.mark_nominal, timing.mark_tolerance), 1'b0, 0);
      end
      wait_drained();
   endtask

   // Random frames across several timing settings
   task automatic test_frames();
      cfg_type plans[6];
      int k;
      int roll;
      int frames;
      plans[0] = '{16'd560, 16'd150, 16'd1690, 16'd300, 16'd560, 16'd300};
      plans[1] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF};
      plans[2] = '{16'hFFFF, 16'd1, 16'd0, 16'd1, 16'hFFFF, 16'd1};
      plans[3] = '{16'd600, 16'd0, 16'd1600, 16'd200, 16'd600, 16'd200};
      plans[4] = '{16'd1000, 16'd300, 16'd1000, 16'd300, 16'd1000, 16'd300};
      plans[5] = '{16'd600, 16'd100, 16'd1600, 16'd0, 16'd600, 16'd200};
      for (k = 0; k < 6; k++) begin
         wait_drained();
         program_timing(plans[k], k == 2);
         // a zero mark tolerance ends every frame that reaches its first checked mark
         frames = (k == 3) ? 4 : 1;
         repeat (frames) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) run_frame(FRAME_CLEAN);
            else if (roll < 70) run_frame(FRAME_MARK_FAULT);
            else if (roll < 88) run_frame(FRAME_SPACE_FAULT);
            else run_frame(FRAME_CUT);
         end
      end
      wait_drained();
   endtask

   // Drive rsp_ready: random stalls, long hold on request
   initial begin : rsp_ready_drive
      int hold_left;
      int stall_left;
      hold_left = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Compare each result beat with the oldest expected part
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_parts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: bits=%h idx=%0d status=%0d",
                        rsp_part_bits, rsp_part_index, rsp_status);
         end else begin
            want = expected_parts.pop_front();
            if (rsp_part_bits !== want.part_bits || rsp_part_index !== want.part_index ||
                rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp bits=%h idx=%0d st=%0d, got bits=%h idx=%0d st=%0d",
                           want.part_bits, want.part_index, want.status,
                           rsp_part_bits, rsp_part_index, rsp_status);
            end
         end
      end
   end

   // End the run when no beat moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_frames();
      wait_drained();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
